// ===== rtl/xia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package xia_pkg;

	localparam int DATA_WIDTH = 32;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_ADC  = 5'd1,
		OP_SUB  = 5'd2,
		OP_SBB  = 5'd3,
		OP_MUL  = 5'd4,
		OP_IMUL = 5'd5,
		OP_DIV  = 5'd6,
		OP_IDIV = 5'd7,
		OP_MOD  = 5'd8,
		OP_IMOD = 5'd9,
		OP_AND  = 5'd10,
		OP_OR   = 5'd11,
		OP_XOR  = 5'd12,
		OP_SHL  = 5'd13,
		OP_SAL  = 5'd14,
		OP_SHR  = 5'd15,
		OP_SAR  = 5'd16
	} xia_op_e;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	typedef struct packed {
		logic [4:0]            command;
		logic [1:0]            size_code;
		logic [DATA_WIDTH-1:0] operand_a;
		logic [DATA_WIDTH-1:0] operand_a_high;
		logic [DATA_WIDTH-1:0] operand_b;
	} xia_cmd_t;

	typedef struct packed {
		logic [2*DATA_WIDTH-1:0] result;
		logic                    carry_flag;
		logic                    parity_flag;
		logic                    zero_flag;
		logic                    sign_flag;
		logic                    overflow_flag;
		logic                    divide_error;
	} xia_rsp_t;

	// Operation handed to the iterative multiply/divide unit.
	typedef struct packed {
		logic       is_div;
		logic       is_signed;
		logic       want_rem;
		logic [1:0] size_code;
	} xia_uop_t;

	typedef struct packed {
		logic cf;
		logic pf;
		logic zf;
		logic sf;
		logic of;
	} xia_flags_t;

	typedef enum logic [1:0] {
		U_IDLE,
		U_STEP,
		U_FIX
	} xia_ustate_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WRITE
	} xia_state_t;

	// Operand at the chosen size, zero or sign extended to 32 bits.
	function automatic logic [DATA_WIDTH-1:0] size_ext(input logic [DATA_WIDTH-1:0] v,
			input logic [1:0] sz, input logic sgn);
		logic [DATA_WIDTH-1:0] r;
		begin
			unique case (sz)
				SZ_8:    r = {{(DATA_WIDTH-8){sgn & v[7]}}, v[7:0]};
				SZ_16:   r = {{(DATA_WIDTH-16){sgn & v[15]}}, v[15:0]};
				default: r = v;
			endcase
			return r;
		end
	endfunction

	function automatic logic [DATA_WIDTH-1:0] size_mask(input logic [1:0] sz);
		logic [DATA_WIDTH-1:0] r;
		begin
			unique case (sz)
				SZ_8:    r = 32'h0000_00ff;
				SZ_16:   r = 32'h0000_ffff;
				default: r = '1;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/xia_iter.sv =====
`timescale 1ns / 1ps
`default_nettype none
module xia_iter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire xia_pkg::xia_uop_t                   op,
	input  wire logic [xia_pkg::DATA_WIDTH-1:0]      a,
	input  wire logic [xia_pkg::DATA_WIDTH-1:0]      ah,
	input  wire logic [xia_pkg::DATA_WIDTH-1:0]      b,
	output logic                                     done,
	output logic [2*xia_pkg::DATA_WIDTH-1:0]         res
);
	import xia_pkg::*;

	localparam int W = DATA_WIDTH;

	xia_ustate_t          state_q, state_d;
	xia_uop_t             op_q;
	logic [W:0]           rem_q;
	logic [2*W-1:0]       acc_q;
	logic [W-1:0]         opb_q;
	logic                 neg_q, nrem_q;
	logic [6:0]           cnt_q;
	logic [2*W-1:0]       res_q;

	logic [W-1:0]         ea, eb, ma, mb;
	logic [2*W-1:0]       dvd, mdvd;
	logic                 na, nb, ndv;
	logic [W:0]           add_x, t;
	logic [W+1:0]         sum;
	logic                 last;

	// Operand magnitudes prepared at start.
	always_comb begin
		ea   = size_ext(a, op.size_code, op.is_signed);
		eb   = op.is_div ? b : size_ext(b, op.size_code, op.is_signed);
		na   = op.is_signed & ea[W-1];
		nb   = op.is_signed & eb[W-1];
		ma   = na ? (~ea + 1'b1) : ea;
		mb   = nb ? (~eb + 1'b1) : eb;
		dvd  = {ah, a};
		ndv  = op.is_signed & dvd[2*W-1];
		mdvd = ndv ? (~dvd + 1'b1) : dvd;
	end

	// The shared adder: add for multiply steps, subtract for divide steps.
	always_comb begin
		t     = {rem_q[W-1:0], acc_q[2*W-1]};
		add_x = op_q.is_div ? t : {1'b0, rem_q[W-1:0]};
		sum   = op_q.is_div ? ({1'b0, add_x} - {2'b0, opb_q})
		                    : ({1'b0, add_x} + {2'b0, opb_q});
		last  = op_q.is_div ? (cnt_q == 7'(2*W-1)) : (cnt_q == 7'(W-1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE:  if (start) state_d = U_STEP;
			U_STEP:  if (last) state_d = U_FIX;
			U_FIX:   state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == U_FIX);
		res  = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					op_q  <= op;
					cnt_q <= '0;
					rem_q <= '0;
					if (op.is_div) begin
						acc_q  <= mdvd;
						opb_q  <= mb;
						neg_q  <= ndv ^ nb;
						nrem_q <= ndv;
					end else begin
						acc_q  <= {{W{1'b0}}, mb};
						opb_q  <= ma;
						neg_q  <= na ^ nb;
						nrem_q <= 1'b0;
					end
				end
			end
			U_STEP: begin
				cnt_q <= cnt_q + 1'b1;
				if (op_q.is_div) begin
					if (!sum[W+1]) begin
						rem_q <= sum[W:0];
						acc_q <= {acc_q[2*W-2:0], 1'b1};
					end else begin
						rem_q <= t;
						acc_q <= {acc_q[2*W-2:0], 1'b0};
					end
				end else begin
					if (acc_q[0]) begin
						rem_q <= {1'b0, sum[W:1]};
						acc_q <= {{W{1'b0}}, sum[0], acc_q[W-1:1]};
					end else begin
						rem_q <= {1'b0, 1'b0, rem_q[W-1:1]};
						acc_q <= {{W{1'b0}}, rem_q[0], acc_q[W-1:1]};
					end
				end
			end
			U_FIX: begin
				if (!op_q.is_div) begin
					res_q <= neg_q ? (~{rem_q[W-1:0], acc_q[W-1:0]} + 1'b1)
					               : {rem_q[W-1:0], acc_q[W-1:0]};
				end else if (op_q.want_rem) begin
					res_q <= {{W{1'b0}}, nrem_q ? (~rem_q[W-1:0] + 1'b1) : rem_q[W-1:0]};
				end else begin
					res_q <= {{W{1'b0}}, neg_q ? (~acc_q[W-1:0] + 1'b1) : acc_q[W-1:0]};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/x86_integer_alu_with_flags.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Integer ALU with stored x86 status flags (CF, PF, ZF, SF, OF; all zero after
// reset). Each command word performs one operation; each produces one response
// word carrying the result, the flags after the operation and a divide error bit.
// Add, subtract, logic and shift words go from the held command register to
// the write stage and then the response register. Multiplies run 32 shift-add
// steps in the shared multiply/divide unit plus fix-up and write, and divides
// and modulos run 64 restoring steps, one quotient bit per cycle, in that same
// unit, plus fix-up and write. A divide by zero skips the unit and goes straight
// to the write stage. The next command word can be accepted once the response
// register has loaded. The block accepts a new command word while the previous
// response word is still waiting in the output register, but holds cmd_stall
// high while it works and while a finished word waits for that register.
module x86_integer_alu_with_flags (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire xia_pkg::xia_cmd_t cmd,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output xia_pkg::xia_rsp_t      rsp
);
	import xia_pkg::*;

	localparam int W = DATA_WIDTH;

	xia_state_t state_q, state_d;
	xia_cmd_t   item_q;
	xia_flags_t flags_q, flags_d;
	xia_rsp_t   rsp_q, rsp_d;
	logic       rsp_valid_q;

	logic       accept, out_free, load_out;
	logic       cmd_is_iter, cmd_div, cmd_zero_div;
	xia_uop_t   uop;
	logic       u_done;
	logic [2*W-1:0] u_res;

	// Accepting a word.
	always_comb begin
		accept       = cmd_valid && !cmd_stall;
		cmd_div      = (cmd.command == OP_DIV) || (cmd.command == OP_IDIV)
		            || (cmd.command == OP_MOD) || (cmd.command == OP_IMOD);
		cmd_is_iter  = cmd_div || (cmd.command == OP_MUL) || (cmd.command == OP_IMUL);
		cmd_zero_div = cmd_div && (cmd.operand_b == '0);
		uop.is_div    = cmd_div;
		uop.is_signed = (cmd.command == OP_IMUL) || (cmd.command == OP_IDIV)
		             || (cmd.command == OP_IMOD);
		uop.want_rem  = (cmd.command == OP_MOD) || (cmd.command == OP_IMOD);
		uop.size_code = cmd.size_code;
	end

	xia_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && cmd_is_iter && !cmd_zero_div),
		.op     (uop),
		.a      (cmd.operand_a),
		.ah     (cmd.operand_a_high),
		.b      (cmd.operand_b),
		.done   (u_done),
		.res    (u_res)
	);

	// Sequencer: a word is either handed to the shared unit or goes straight
	// to the write stage, which waits until the output register is free.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = (cmd_is_iter && !cmd_zero_div) ? ST_RUN : ST_WRITE;
			ST_RUN:   if (u_done) state_d = ST_WRITE;
			ST_WRITE: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_free  = !rsp_valid_q || !rsp_stall;
		cmd_stall = (state_q != ST_IDLE);
		load_out  = (state_q == ST_WRITE) && out_free;
		rsp_valid = rsp_valid_q;
		rsp       = rsp_q;
	end

	// Operations that skip the shared unit, and flag computation, taken from the held word.
	logic [W-1:0]   a, b, m, v, hi, r, subtrahend;
	logic [W:0]     sum33;
	logic [2*W-1:0] hm, wsh;
	logic [4:0]     cnt, nm1, sgn_bit;
	logic           c, o, cf_in, set_all, p_sgn;
	logic [W-1:0]   sx, sar_v;

	always_comb begin
		a       = item_q.operand_a;
		b       = item_q.operand_b;
		m       = size_mask(item_q.size_code);
		hm      = ~{{W{1'b0}}, m};
		v       = a & m;
		hi      = a & ~m;
		cnt     = b[4:0];
		nm1     = (item_q.size_code == SZ_8) ? 5'd7 :
		          (item_q.size_code == SZ_16) ? 5'd15 : 5'd31;
		cf_in   = flags_q.cf;
		sx      = size_ext(v, item_q.size_code, 1'b1);
		wsh     = {{W{1'b0}}, v} << cnt;
		sar_v   = $signed(sx) >>> cnt;
		sum33   = '0;
		subtrahend = '0;
		r       = '0;
		c       = 1'b0;
		o       = 1'b0;
		set_all = 1'b0;
		p_sgn   = 1'b0;
		// Arithmetic and logic words take the sign from bit 31; shifts from
		// the top bit at the chosen size.
		sgn_bit = 5'(W-1);
		flags_d = flags_q;
		rsp_d   = '0;

		unique case (item_q.command)
			OP_ADD, OP_ADC: begin
				sum33 = {1'b0, a} + {1'b0, b}
				      + {{W{1'b0}}, (item_q.command == OP_ADC) & cf_in};
				r     = sum33[W-1:0];
				c     = sum33[W];
				o     = ~(a[W-1] ^ b[W-1]) & (a[W-1] ^ r[W-1]);
				set_all = 1'b1;
			end
			OP_SUB, OP_SBB: begin
				sum33 = {1'b0, b} + {{W{1'b0}}, (item_q.command == OP_SBB) & cf_in};
				subtrahend = sum33[W-1:0];
				r     = a - subtrahend;
				c     = ({1'b0, a} < sum33);
				o     = (a[W-1] ^ b[W-1]) & (a[W-1] ^ r[W-1]);
				set_all = 1'b1;
			end
			OP_AND, OP_OR, OP_XOR: begin
				r = (item_q.command == OP_AND) ? (a & b) :
				    (item_q.command == OP_OR)  ? (a | b) : (a ^ b);
				set_all = 1'b1;
			end
			OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
				sgn_bit = nm1;
				if (cnt != '0) begin
					if (item_q.command == OP_SHR) begin
						r = v >> cnt;
						c = v[5'(cnt - 1'b1)];
						o = v[nm1];
					end else if (item_q.command == OP_SAR) begin
						r = sar_v & m;
						c = sx[5'(cnt - 1'b1)];
					end else begin
						r = wsh[W-1:0] & m;
						c = wsh[nm1 + 6'd1];
						o = r[nm1] ^ c;
					end
					set_all = 1'b1;
				end
			end
			OP_MUL, OP_IMUL: begin
				p_sgn = u_res[nm1];
				c = (item_q.command == OP_MUL) ? |(u_res & hm)
				                              : |((u_res ^ {(2*W){p_sgn}}) & hm);
				flags_d.cf = c;
				flags_d.of = c;
			end
			default: ;
		endcase

		// Shift results are already cut to the chosen size.
		if (set_all) begin
			flags_d.cf = c;
			flags_d.pf = ~^r[7:0];
			flags_d.zf = (r == '0);
			flags_d.sf = r[sgn_bit];
			flags_d.of = o;
		end

		unique case (item_q.command)
			OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_AND, OP_OR, OP_XOR:
				rsp_d.result = {{W{1'b0}}, r};
			OP_SHL, OP_SAL, OP_SHR, OP_SAR:
				rsp_d.result = {{W{1'b0}}, (cnt == '0) ? a : (hi | r)};
			OP_MUL, OP_IMUL:
				rsp_d.result = u_res;
			OP_DIV, OP_IDIV, OP_MOD, OP_IMOD: begin
				rsp_d.divide_error = (b == '0);
				rsp_d.result       = (b == '0) ? '0 : u_res;
			end
			default: ;
		endcase

		rsp_d.carry_flag    = flags_d.cf;
		rsp_d.parity_flag   = flags_d.pf;
		rsp_d.zero_flag     = flags_d.zf;
		rsp_d.sign_flag     = flags_d.sf;
		rsp_d.overflow_flag = flags_d.of;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			flags_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				flags_q     <= flags_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (load_out) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire
